@@ design/qph_pkg.sv @@
// ----------------------------------------------------------------------------
// qph_pkg: shared definitions of the quadratic probe hash table
// Table geometry, operation codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package qph_pkg;

  localparam int TABLE_SIZE  = 1021;
  localparam int SLOT_W      = 10;
  localparam int KEY_W       = 31;
  localparam int KIND_W      = 2;
  localparam int PROBE_LIMIT = (TABLE_SIZE + 1) / 2;
  localparam int PROBE_W     = $clog2(PROBE_LIMIT);
  // Weight of one unit of the bits above the slot field, modulo the size.
  localparam int FOLD        = (2 ** SLOT_W) % TABLE_SIZE;
  localparam int ENTRY_W     = KEY_W + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CHECK,
    ST_RDWAIT,
    ST_RESP
  } state_e;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_ZERO,
    RES_FAIL,
    RES_PROBE,
    RES_READ
  } res_e;

  typedef struct packed {
    logic clr_we;
    logic load;
    logic hash_step;
    logic probe_init;
    logic rd_in;
    logic rd_cur;
    logic advance;
    logic ins_we;
    res_e res_sel;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] in_kind;
    logic              in_slot_ok;
    logic              clr_done;
    logic              hash_done;
    logic              hit;
    logic              empty;
    logic              last_probe;
    logic              is_insert;
    logic              out_free;
  } dp_sts_t;

endpackage

@@ design/qph_if.sv @@
// ----------------------------------------------------------------------------
// qph_if: request and result channels of the hash table
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface qph_in_if import qph_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key;
  logic [SLOT_W-1:0] slot_in;

  modport source (output valid, kind, key, slot_in, input ready);
  modport sink   (input valid, kind, key, slot_in, output ready);
endinterface

interface qph_out_if import qph_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_out;
  logic              found;
  logic [KEY_W-1:0]  stored_key;
  logic              failed;

  modport source (output valid, slot_out, found, stored_key, failed, input ready);
  modport sink   (input valid, slot_out, found, stored_key, failed, output ready);
endinterface

@@ design/quadratic_probe_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_unit: open-addressing hash set, quadratic probing
// Lookup, insert and slot read over a 1021-slot table of 31-bit keys.
// ----------------------------------------------------------------------------
// Requests arrive on in_i (kind, key, slot_in) and each gives exactly one
// transaction on out_o (slot_out, found, stored_key, failed), in order.
// Both channels are valid/ready.
// After reset a clearing pass writes every slot of the store empty, one slot
// per cycle, while in_i.ready stays low.
// One request is worked on at a time. A lookup or insert reduces the key
// modulo the size by folding, then runs each probe on the single RAM read
// port as a read and then a compare, for at most 511 probes. A slot read
// uses the same read port; an out-of-range read or unused code does not.
// The result goes to an output register; the block accepts the next request
// in the cycle after that register is loaded, even while out_o is stalled.
// A finished result waits inside the block while the output register still
// holds an earlier one that has not been taken.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_unit import qph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  qph_in_if.sink    in_i,
  qph_out_if.source out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  qph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qph_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_kind_i    (in_i.kind),
    .in_key_i     (in_i.key),
    .in_slot_i    (in_i.slot_in),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_slot_o   (out_o.slot_out),
    .out_found_o  (out_o.found),
    .out_key_o    (out_o.stored_key),
    .out_failed_o (out_o.failed)
  );

endmodule

@@ design/qph_ram.sv @@
// ----------------------------------------------------------------------------
// qph_ram: generic single write, single read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module qph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/qph_ctrl.sv @@
// ----------------------------------------------------------------------------
// qph_ctrl: operation sequencer of the hash table
// Runs the clearing pass, the key reduction, the probe loop and the result
// handoff by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module qph_ctrl import qph_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (sts_i.in_kind)
            KIND_LOOKUP, KIND_INSERT: state_d = ST_HASH;
            KIND_READ: begin
              if (sts_i.in_slot_ok) begin
                cmd_o.rd_in = 1'b1;
                state_d     = ST_RDWAIT;
              end else begin
                cmd_o.res_sel = RES_ZERO;
                state_d       = ST_RESP;
              end
            end
            default: begin
              cmd_o.res_sel = RES_ZERO;
              state_d       = ST_RESP;
            end
          endcase
        end
      end
      ST_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.probe_init = 1'b1;
          state_d          = ST_PROBE;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      ST_PROBE: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (sts_i.hit) begin
          cmd_o.res_sel = RES_PROBE;
          cmd_o.ins_we  = sts_i.is_insert && sts_i.empty;
          state_d       = ST_RESP;
        end else if (sts_i.last_probe) begin
          cmd_o.res_sel = RES_FAIL;
          state_d       = ST_RESP;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_PROBE;
        end
      end
      ST_RDWAIT: begin
        cmd_o.res_sel = RES_READ;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

@@ design/qph_dp.sv @@
// ----------------------------------------------------------------------------
// qph_dp: datapath of the hash table
// Holds the slot store, the key reduction, the probe position and step, the
// result register and the output register.
// ----------------------------------------------------------------------------
module qph_dp import qph_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [KIND_W-1:0] in_kind_i,
  input  logic [KEY_W-1:0]  in_key_i,
  input  logic [SLOT_W-1:0] in_slot_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SLOT_W-1:0] out_slot_o,
  output logic              out_found_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic              out_failed_o
);

  logic [KEY_W-1:0]   key_q;
  logic [KEY_W-1:0]   x_q;
  logic [SLOT_W-1:0]  cur_q;
  logic [PROBE_W-1:0] k_q;
  logic               ins_q;
  logic [SLOT_W-1:0]  clr_q;

  logic [SLOT_W-1:0]  res_slot_q;
  logic               res_found_q;
  logic [KEY_W-1:0]   res_key_q;
  logic               res_fail_q;

  logic               out_valid_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic               out_found_q;
  logic [KEY_W-1:0]   out_key_q;
  logic               out_fail_q;

  logic [KEY_W-1:0]   fold_d;
  logic [SLOT_W-1:0]  home;
  logic [SLOT_W:0]    step_sum;
  logic [SLOT_W-1:0]  cur_next;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [SLOT_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               occ;
  logic [KEY_W-1:0]   rkey;

  // Since 2^SLOT_W is FOLD modulo the size, the upper bits fold down with
  // weight FOLD; the value shrinks every step until it fits the slot field.
  assign fold_d = KEY_W'(FOLD) * KEY_W'(x_q[KEY_W-1:SLOT_W]) + KEY_W'(x_q[SLOT_W-1:0]);
  assign home   = (x_q[SLOT_W-1:0] >= SLOT_W'(TABLE_SIZE))
                ? x_q[SLOT_W-1:0] - SLOT_W'(TABLE_SIZE) : x_q[SLOT_W-1:0];

  // Probe k+1 moves 2k+1 slots on from probe k.
  assign step_sum = {1'b0, cur_q} + (SLOT_W+1)'({k_q, 1'b1});
  assign cur_next = (step_sum >= (SLOT_W+1)'(TABLE_SIZE))
                  ? SLOT_W'(step_sum - (SLOT_W+1)'(TABLE_SIZE)) : SLOT_W'(step_sum);

  assign occ  = ram_rdata[KEY_W];
  assign rkey = ram_rdata[KEY_W-1:0];

  always_comb begin
    ram_we    = cmd_i.clr_we || cmd_i.ins_we;
    ram_waddr = cmd_i.clr_we ? clr_q : cur_q;
    ram_wdata = cmd_i.clr_we ? '0 : {1'b1, key_q};
    ram_re    = cmd_i.rd_in || cmd_i.rd_cur;
    ram_raddr = cmd_i.rd_in ? in_slot_i : cur_q;
  end

  qph_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_we) begin
        clr_q <= clr_q + SLOT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= in_key_i;
      x_q   <= in_key_i;
      cur_q <= in_slot_i;
      ins_q <= (in_kind_i == KIND_INSERT);
    end
    if (cmd_i.hash_step) begin
      x_q <= fold_d;
    end
    if (cmd_i.probe_init) begin
      cur_q <= home;
      k_q   <= '0;
    end
    if (cmd_i.advance) begin
      cur_q <= cur_next;
      k_q   <= k_q + PROBE_W'(1);
    end
    unique case (cmd_i.res_sel)
      RES_HOLD: ;
      RES_ZERO: begin
        res_slot_q  <= '0;
        res_found_q <= 1'b0;
        res_key_q   <= '0;
        res_fail_q  <= 1'b0;
      end
      RES_FAIL: begin
        res_slot_q  <= '0;
        res_found_q <= 1'b0;
        res_key_q   <= '0;
        res_fail_q  <= 1'b1;
      end
      RES_PROBE: begin
        res_slot_q  <= cur_q;
        res_found_q <= occ;
        res_key_q   <= occ ? rkey : (ins_q ? key_q : '0);
        res_fail_q  <= 1'b0;
      end
      RES_READ: begin
        res_slot_q  <= cur_q;
        res_found_q <= occ;
        res_key_q   <= occ ? rkey : '0;
        res_fail_q  <= 1'b0;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_slot_q  <= res_slot_q;
      out_found_q <= res_found_q;
      out_key_q   <= res_key_q;
      out_fail_q  <= res_fail_q;
    end
  end

  always_comb begin
    sts_o.in_kind    = in_kind_i;
    sts_o.in_slot_ok = in_slot_i < SLOT_W'(TABLE_SIZE);
    sts_o.clr_done   = clr_q == SLOT_W'(TABLE_SIZE - 1);
    sts_o.hash_done  = x_q[KEY_W-1:SLOT_W] == '0;
    sts_o.hit        = !occ || (rkey == key_q);
    sts_o.empty      = !occ;
    sts_o.last_probe = k_q == PROBE_W'(PROBE_LIMIT - 1);
    sts_o.is_insert  = ins_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_slot_o   = out_slot_q;
  assign out_found_o  = out_found_q;
  assign out_key_o    = out_key_q;
  assign out_failed_o = out_fail_q;

endmodule

@@ design/qph_checker.sv @@
// ----------------------------------------------------------------------------
// qph_checker: port-level checks of the hash table
// Watches both channels of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
module qph_checker import qph_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [SLOT_W-1:0] slot_out_i,
  input logic              found_i,
  input logic [KEY_W-1:0]  stored_key_i,
  input logic              failed_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(slot_out_i) && $stable(found_i)
                                   && $stable(stored_key_i) && $stable(failed_i))
    else $error("stalled result changed");

  // One request at a time: a new transaction cannot follow directly.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while another is in progress");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && failed_i |-> slot_out_i == '0 && !found_i && stored_key_i == '0)
    else $error("failed result carries nonzero fields");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> slot_out_i < SLOT_W'(TABLE_SIZE))
    else $error("result slot beyond the table");

endmodule

bind quadratic_probe_hash_table_unit qph_checker u_qph_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .slot_out_i   (out_o.slot_out),
  .found_i      (out_o.found),
  .stored_key_i (out_o.stored_key),
  .failed_i     (out_o.failed)
);

@@ bench/tb_quadratic_probe_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// tb_quadratic_probe_hash_table_unit: self-checking bench of the hash table
// Sends lookups, inserts, slot reads and the unused code, and keeps a shadow copy of the table
// to work out each result. Every result transaction is checked in order. A
// short directed table runs first. Random traffic around a few crowded home
// slots follows. A last pass fills one probe path until the probe limit hits.
// ----------------------------------------------------------------------------
module tb_quadratic_probe_hash_table_unit;
  import qph_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
  localparam logic [KEY_W-1:0]  KEY_MAX      = '1;
  localparam int unsigned       MAX_MULT     = (32'h7fff_ffff - TABLE_SIZE) / TABLE_SIZE;
  localparam int                RANDOM_ITEMS = 120;
  localparam int                LONG_HOLD    = 400;
  localparam int                DRAIN_CYCLES = 2 * PROBE_LIMIT + 16;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              found;
    logic [KEY_W-1:0]  stored_key;
    logic              failed;
  } table_result_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    bit                fixed;
    table_result_t     want;
  } probe_row_t;

  localparam table_result_t ZERO_RESULT = '0;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  qph_in_if  req_if ();
  qph_out_if res_if ();

  quadratic_probe_hash_table_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the table and bookkeeping.
  bit               shadow_used [TABLE_SIZE];
  logic [KEY_W-1:0] shadow_key  [TABLE_SIZE];
  table_result_t    pending_results [$];
  logic [KEY_W-1:0] stored_keys [$];
  int unsigned      filled_slots [$];
  probe_row_t       directed_rows [$];
  int unsigned      cluster_home [4];
  int               kind_count [4];
  int               mismatches        = 0;
  int               results_checked   = 0;
  int               limit_hits        = 0;
  int               key_hits          = 0;
  int               hold_off_requests = 0;
  int               hold_off_served   = 0;
  bit               sink_idling       = 1'b1;

  // Applies one request to the shadow table and returns the result it gives.
  function automatic table_result_t hash_apply(logic [KIND_W-1:0] kind,
                                               logic [KEY_W-1:0] key,
                                               logic [SLOT_W-1:0] slot_in);
    table_result_t r;
    int unsigned   pos;
    int unsigned   k;
    bit            hit;
    r = '0;
    if (kind == KIND_LOOKUP || kind == KIND_INSERT) begin
      pos = key % TABLE_SIZE;
      hit = 1'b0;
      for (k = 0; k < PROBE_LIMIT; k++) begin
        if (k != 0) begin
          pos += 2 * k - 1;
          if (pos >= TABLE_SIZE) pos -= TABLE_SIZE;
        end
        if (!shadow_used[pos] || shadow_key[pos] == key) begin
          hit = 1'b1;
          break;
        end
      end
      if (!hit) begin
        r.failed = 1'b1;
      end else begin
        r.slot  = SLOT_W'(pos);
        r.found = shadow_used[pos];
        if (kind == KIND_INSERT && !shadow_used[pos]) begin
          shadow_used[pos] = 1'b1;
          shadow_key[pos]  = key;
        end
        r.stored_key = shadow_used[pos] ? shadow_key[pos] : '0;
      end
    end else if (kind == KIND_READ) begin
      if (slot_in < TABLE_SIZE) begin
        r.slot       = slot_in;
        r.found      = shadow_used[slot_in];
        r.stored_key = shadow_used[slot_in] ? shadow_key[slot_in] : '0;
      end
    end
    return r;
  endfunction

  function automatic string show(table_result_t r);
    return $sformatf("slot %0d found %0b key 0x%h failed %0b",
                     r.slot, r.found, r.stored_key, r.failed);
  endfunction

  function automatic void add_row(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                  logic [SLOT_W-1:0] slot, bit fixed,
                                  table_result_t want);
    probe_row_t row;
    row.kind  = kind;
    row.key   = key;
    row.slot  = slot;
    row.fixed = fixed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Offers one request and returns once it has been taken. The valid stays
  // high so that a following request goes out back to back.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                              input logic [SLOT_W-1:0] slot, input bit fixed,
                              input table_result_t want, output table_result_t predicted);
    req_if.valid   <= 1'b1;
    req_if.kind    <= kind;
    req_if.key     <= key;
    req_if.slot_in <= slot;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predicted = hash_apply(kind, key, slot);
    pending_results.push_back(fixed ? want : predicted);
    kind_count[kind]++;
    if (kind == KIND_INSERT && !predicted.found && !predicted.failed) begin
      stored_keys.push_back(key);
      filled_slots.push_back(predicted.slot);
    end
  endtask

  task automatic pause_sender(input int cycles);
    req_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Result side: random ready pattern, plus long hold-offs on request.
  initial begin : result_sink
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_requests != hold_off_served) begin
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_off_served++;
      end else if (sink_idling && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    table_result_t got;
    table_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.slot_out, res_if.found, res_if.stored_key, res_if.failed};
      if (got.failed) limit_hits++;
      if (got.found)  key_hits++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with no request outstanding: %s", show(got)));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want)
          note_mismatch($sformatf("result %0d: expected %s, got %s",
                                  results_checked, show(want), show(got)));
      end
    end
  end

  initial begin : stimulus
    table_result_t     predicted;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    int unsigned       random_done;
    int unsigned       pick;
    int unsigned       fill_home;
    int unsigned       fill_count;
    bit                held;
    bit                paused;
    bit                sender_idling;

    req_if.valid   = 1'b0;
    req_if.kind    = KIND_LOOKUP;
    req_if.key     = '0;
    req_if.slot_in = '0;
    held           = 1'b0;
    paused         = 1'b0;
    foreach (kind_count[i]) kind_count[i] = 0;

    // Homes at both ends of the table exercise the wrap of the probe step.
    cluster_home[0] = 0;
    cluster_home[1] = TABLE_SIZE - 1;
    cluster_home[2] = $urandom_range(1, TABLE_SIZE - 2);
    cluster_home[3] = $urandom_range(1, TABLE_SIZE - 2);

    // Empty table, out-of-range reads and the unused code.
    add_row(KIND_READ,   '0,      10'd0,    1'b1, ZERO_RESULT);
    add_row(KIND_READ,   KEY_MAX, 10'd1020, 1'b1, table_result_t'{10'd1020, 1'b0, 31'd0, 1'b0});
    add_row(KIND_READ,   '0,      10'd1021, 1'b1, ZERO_RESULT);
    add_row(KIND_READ,   KEY_MAX, 10'd1023, 1'b1, ZERO_RESULT);
    add_row(KIND_UNUSED, KEY_MAX, 10'd1023, 1'b1, ZERO_RESULT);
    // Smallest and largest keys, a repeated insert and a read of a filled slot.
    add_row(KIND_LOOKUP, '0,      10'd0,    1'b1, ZERO_RESULT);
    add_row(KIND_INSERT, '0,      10'd0,    1'b1, ZERO_RESULT);
    add_row(KIND_INSERT, '0,      10'd0,    1'b1, table_result_t'{10'd0, 1'b1, 31'd0, 1'b0});
    add_row(KIND_READ,   '0,      10'd0,    1'b1, table_result_t'{10'd0, 1'b1, 31'd0, 1'b0});
    add_row(KIND_INSERT, KEY_MAX, 10'd0,    1'b1, table_result_t'{10'd53, 1'b0, KEY_MAX, 1'b0});
    add_row(KIND_LOOKUP, KEY_MAX, 10'd0,    1'b1, table_result_t'{10'd53, 1'b1, KEY_MAX, 1'b0});
    // Collisions on home slot 0, then on the last slot so that probing wraps.
    add_row(KIND_INSERT, 31'd1021,  10'd0,   1'b0, ZERO_RESULT);
    add_row(KIND_INSERT, 31'd2042,  10'd0,   1'b0, ZERO_RESULT);
    add_row(KIND_LOOKUP, 31'd2042,  10'd0,   1'b0, ZERO_RESULT);
    add_row(KIND_LOOKUP, 31'd3063,  10'd0,   1'b0, ZERO_RESULT);
    add_row(KIND_INSERT, 31'd1020,  10'd0,   1'b0, ZERO_RESULT);
    add_row(KIND_INSERT, 31'd2041,  10'd0,   1'b0, ZERO_RESULT);
    add_row(KIND_READ,   '0,        10'd3,   1'b0, ZERO_RESULT);
    add_row(KIND_INSERT, KEY_MAX - 31'd1021, 10'd0, 1'b0, ZERO_RESULT);
    add_row(KIND_LOOKUP, 31'h5555_5555, 10'h2aa, 1'b0, ZERO_RESULT);
    add_row(KIND_INSERT, 31'h2aaa_aaaa, 10'h155, 1'b0, ZERO_RESULT);
    add_row(KIND_UNUSED, '0,        10'd0,   1'b1, ZERO_RESULT);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].slot,
                   directed_rows[i].fixed, directed_rows[i].want, predicted);

    // Random traffic. Four keys in ten are drawn on the crowded homes so that probe
    // chains grow long; many lookups and reads target keys already stored.
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      sink_idling   = ((random_done / 10) % 4) != 3;
      sender_idling = ((random_done / 16) % 3) != 2 &&
                      !(random_done >= 40 && random_done < 48);
      if (!held && random_done >= 40) begin
        // The sender keeps offering while results back up.
        hold_off_requests++;
        held = 1'b1;
      end
      if (!paused && random_done >= 80) begin
        pause_sender(1);
        while (pending_results.size() != 0) @(posedge clk_i);
        paused = 1'b1;
      end
      if (sender_idling && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 13));

      pick = $urandom_range(0, 99);
      if (pick < 40)      kind = KIND_INSERT;
      else if (pick < 75) kind = KIND_LOOKUP;
      else if (pick < 95) kind = KIND_READ;
      else                kind = KIND_UNUSED;

      pick = $urandom_range(0, 9);
      if (pick < 4 && stored_keys.size() != 0)
        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      else if (pick < 8)
        key = KEY_W'(cluster_home[$urandom_range(0, 3)] +
                     TABLE_SIZE * $urandom_range(0, MAX_MULT));
      else
        key = KEY_W'($urandom);

      slot = SLOT_W'($urandom);
      if (kind == KIND_READ) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          slot = SLOT_W'($urandom_range(TABLE_SIZE, 2 ** SLOT_W - 1));
        else if (pick < 5 && filled_slots.size() != 0)
          slot = SLOT_W'(filled_slots[$urandom_range(0, filled_slots.size() - 1)]);
        else
          slot = SLOT_W'($urandom_range(0, TABLE_SIZE - 1));
      end

      send_request(kind, key, slot, 1'b0, ZERO_RESULT, predicted);
      if (kind != KIND_UNUSED) random_done++;
    end

    // Fresh keys that share one home fill its whole probe path; the insert
    // after that runs out of probes. No idling on either side from here on.
    sink_idling = 1'b0;
    fill_home   = $urandom_range(0, TABLE_SIZE - 1);
    fill_count  = 0;
    predicted   = ZERO_RESULT;
    while (!predicted.failed && fill_count < PROBE_LIMIT + 8) begin
      send_request(KIND_INSERT, KEY_W'(fill_home + TABLE_SIZE * (MAX_MULT - fill_count)),
                   SLOT_W'($urandom), 1'b0, ZERO_RESULT, predicted);
      fill_count++;
    end
    send_request(KIND_LOOKUP, KEY_W'(fill_home + TABLE_SIZE * (MAX_MULT - fill_count)),
                 SLOT_W'($urandom), 1'b0, ZERO_RESULT, predicted);
    send_request(KIND_LOOKUP, KEY_W'(fill_home + TABLE_SIZE * MAX_MULT),
                 SLOT_W'($urandom), 1'b0, ZERO_RESULT, predicted);
    send_request(KIND_READ, '0, SLOT_W'(fill_home), 1'b0, ZERO_RESULT, predicted);
    send_request(KIND_INSERT, KEY_MAX, SLOT_W'($urandom), 1'b0, ZERO_RESULT, predicted);
    req_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Compared %0d results: %0d lookups, %0d inserts, %0d slot reads, %0d unused codes.",
             results_checked, kind_count[KIND_LOOKUP], kind_count[KIND_INSERT],
             kind_count[KIND_READ], kind_count[KIND_UNUSED]);
    $display("Results with the key present: %0d; probe-limit failures: %0d (path of home %0d).",
             key_hits, limit_hits, fill_home);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("quadratic_probe_hash_table_unit test passed");
    end else begin
      $display("quadratic_probe_hash_table_unit test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #25_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("quadratic_probe_hash_table_unit test failed");
    $finish;
  end

endmodule
